@@ rtl/core/sat_pkg.sv @@
// shared types and constants of the polygon separating-axis collision block
// no dependencies; used by sat_ctrl, sat_dp and the top level
package sat_pkg;

	localparam int COORD_W = 32;   // Q16.16 coordinate
	localparam int VTX_W   = 64;   // stored vertex: y high, x low
	localparam int HALF_W  = 31;   // halved edge magnitude
	localparam int SQ_W    = 62;   // square of a halved magnitude
	localparam int ROOT_W  = 64;   // integer square root working width
	localparam int LEN_W   = 32;   // edge length
	localparam int FRAC_W  = 15;   // Q1.15 fraction bits of the axis
	localparam int NORM_W  = 16;   // signed Q1.15 axis component
	localparam int DIV_W   = 48;   // divider remainder width
	localparam int PROJ_W  = 48;   // exact projection
	localparam int DIFF_W  = 49;   // gap between two projection ranges
	localparam int MTV_W   = 50;   // signed penetration depth
	localparam int PROD_W  = 65;   // axis magnitude times penetration
	localparam int RND_SH  = 30;   // scale of that product down to Q16.16

	typedef enum logic [1:0] {
		ST_SEP = 2'd0,
		ST_OVL = 2'd1,
		ST_ERR = 2'd2
	} status_t;

	typedef struct packed {
		logic    in_ready;
		logic    test_init;
		logic    rd_poly;
		logic    ld_a;
		logic    ld_edge;
		logic    sq_x;
		logic    sq_y;
		logic    sqrt_init;
		logic    sqrt_step;
		logic    div_init;
		logic    div_step;
		logic    norm_ld;
		logic    proj_vld;
		logic    proj_tgt;
		logic    proj_first;
		logic    eval_diff;
		logic    eval_best;
		logic    push_mul;
		logic    push_rnd;
		logic    push_sel;
		logic    out_load;
		status_t out_st;
		logic    clr_counts;
	} cmd_t;

	typedef struct packed {
		logic cnt_err;
		logic sep;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/core/convex_polygon_sat_collision.sv @@
// Separating-axis collision test for two convex polygons. Vertices come in one beat each,
// tagged with their polygon, and are taken in one cycle each. The beat marked last starts
// the test, during which no vertex is taken. The test runs over every edge of the first,
// then the second polygon; for each edge a 32-step integer square root and a 16-step
// divider build the unit axis, then both vertex lists are streamed through one memory
// read port each for the projections. The walk stops at the first separating edge; an
// empty or overflowed polygon skips the walk. The verdict is loaded and the next beat
// is taken only once the previous verdict has been taken.
// Depends on sat_pkg, sat_ctrl, sat_dp and sat_ram.
module convex_polygon_sat_collision #(
	parameter int MAX_VERTICES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               which_polygon,
	input  logic signed [31:0] vertex_x,
	input  logic signed [31:0] vertex_y,
	input  logic               last_vertex,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] push_x,
	output logic signed [31:0] push_y
);

	localparam int IW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 2);

	sat_pkg::cmd_t cmd;
	sat_pkg::sts_t sts;
	logic [IW-1:0] rd_addr;
	logic [CW-1:0] cnt0, cnt1;

	sat_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_vertex (last_vertex),
		.sts         (sts),
		.cnt0        (cnt0),
		.cnt1        (cnt1),
		.cmd         (cmd),
		.rd_addr     (rd_addr)
	);

	sat_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.rd_addr       (rd_addr),
		.in_valid      (in_valid),
		.which_polygon (which_polygon),
		.vertex_x      (vertex_x),
		.vertex_y      (vertex_y),
		.out_stall     (out_stall),
		.sts           (sts),
		.cnt0          (cnt0),
		.cnt1          (cnt1),
		.out_valid     (out_valid),
		.status        (status),
		.push_x        (push_x),
		.push_y        (push_y)
	);

	assign in_stall = ~cmd.in_ready;

endmodule

@@ rtl/core/sat_ram.sv @@
// generic single-write, single-read memory with registered read data
// no dependencies
module sat_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/sat_ctrl.sv @@
// sequencer of the collision test: loading, edge walk, axis build, projection and result
// depends on sat_pkg
module sat_ctrl #(
	parameter int MAX_VERTICES = 16,
	localparam int IW = $clog2(MAX_VERTICES),
	localparam int CW = $clog2(MAX_VERTICES + 2)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            last_vertex,
	input  sat_pkg::sts_t   sts,
	input  logic [CW-1:0]   cnt0,
	input  logic [CW-1:0]   cnt1,
	output sat_pkg::cmd_t   cmd,
	output logic [IW-1:0]   rd_addr
);

	typedef enum logic [21:0] {
		S_IDLE  = 22'h000001,
		S_CHECK = 22'h000002,
		S_RDA   = 22'h000004,
		S_RDB   = 22'h000008,
		S_EDGE  = 22'h000010,
		S_SQX   = 22'h000020,
		S_SQY   = 22'h000040,
		S_SQRT0 = 22'h000080,
		S_SQRT  = 22'h000100,
		S_DIV0  = 22'h000200,
		S_DIV   = 22'h000400,
		S_NORM  = 22'h000800,
		S_PROJ  = 22'h001000,
		S_DRN1  = 22'h002000,
		S_DRN2  = 22'h004000,
		S_EV1   = 22'h008000,
		S_EV2   = 22'h010000,
		S_PMX   = 22'h020000,
		S_PRX   = 22'h040000,
		S_PMY   = 22'h080000,
		S_PRY   = 22'h100000,
		S_DONE  = 22'h200000
	} state_t;

	state_t           state_q, state_d;
	logic             poly_q, poly_d;
	logic             phase_q, phase_d;
	logic [IW-1:0]    ei_q, ei_d;
	logic [IW-1:0]    vi_q, vi_d;
	logic [4:0]       step_q, step_d;
	sat_pkg::status_t res_q, res_d;

	logic [CW-1:0] n_edge, n_proj;
	logic          ei_last, vi_last;
	logic [IW-1:0] ei_inc, nxt_addr;

	assign n_edge   = poly_q ? cnt1 : cnt0;
	assign n_proj   = (phase_q ^ poly_q) ? cnt1 : cnt0;
	assign ei_last  = (CW'(ei_q) + CW'(1)) == n_edge;
	assign vi_last  = (CW'(vi_q) + CW'(1)) == n_proj;
	assign ei_inc   = ei_q + IW'(1);
	// closing edge wraps back to the first vertex
	assign nxt_addr = ei_last ? '0 : ei_inc;

	always_comb begin
		cmd     = '0;
		cmd.out_st = res_q;
		rd_addr = ei_q;
		cmd.rd_poly = poly_q;
		state_d = state_q;
		poly_d  = poly_q;
		phase_d = phase_q;
		ei_d    = ei_q;
		vi_d    = vi_q;
		step_d  = step_q;
		res_d   = res_q;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid && last_vertex) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.test_init = 1'b1;
				if (sts.cnt_err) begin
					res_d   = sat_pkg::ST_ERR;
					state_d = S_DONE;
				end else begin
					poly_d  = 1'b0;
					ei_d    = '0;
					state_d = S_RDA;
				end
			end
			S_RDA: begin
				state_d = S_RDB;
			end
			S_RDB: begin
				cmd.ld_a = 1'b1;
				rd_addr  = nxt_addr;
				state_d  = S_EDGE;
			end
			S_EDGE: begin
				cmd.ld_edge = 1'b1;
				state_d     = S_SQX;
			end
			S_SQX: begin
				cmd.sq_x = 1'b1;
				state_d  = S_SQY;
			end
			S_SQY: begin
				cmd.sq_y = 1'b1;
				state_d  = S_SQRT0;
			end
			S_SQRT0: begin
				cmd.sqrt_init = 1'b1;
				step_d        = '0;
				state_d       = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				step_d        = step_q + 5'd1;
				if (step_q == 5'd31) begin
					state_d = S_DIV0;
				end
			end
			S_DIV0: begin
				cmd.div_init = 1'b1;
				step_d       = '0;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				step_d       = step_q + 5'd1;
				if (step_q == 5'd15) begin
					state_d = S_NORM;
				end
			end
			S_NORM: begin
				cmd.norm_ld = 1'b1;
				vi_d        = '0;
				phase_d     = 1'b0;
				state_d     = S_PROJ;
			end
			S_PROJ: begin
				// own polygon first, then the other one
				rd_addr        = vi_q;
				cmd.rd_poly    = phase_q ^ poly_q;
				cmd.proj_vld   = 1'b1;
				cmd.proj_tgt   = phase_q;
				cmd.proj_first = (vi_q == '0);
				if (vi_last) begin
					vi_d = '0;
					if (!phase_q) begin
						phase_d = 1'b1;
					end else begin
						state_d = S_DRN1;
					end
				end else begin
					vi_d = vi_q + IW'(1);
				end
			end
			S_DRN1: begin
				state_d = S_DRN2;
			end
			S_DRN2: begin
				state_d = S_EV1;
			end
			S_EV1: begin
				cmd.eval_diff = 1'b1;
				state_d       = S_EV2;
			end
			S_EV2: begin
				cmd.eval_best = 1'b1;
				if (sts.sep) begin
					res_d   = sat_pkg::ST_SEP;
					state_d = S_DONE;
				end else if (!ei_last) begin
					ei_d    = ei_inc;
					state_d = S_RDA;
				end else if (!poly_q) begin
					poly_d  = 1'b1;
					ei_d    = '0;
					state_d = S_RDA;
				end else begin
					state_d = S_PMX;
				end
			end
			S_PMX: begin
				cmd.push_mul = 1'b1;
				state_d      = S_PRX;
			end
			S_PRX: begin
				cmd.push_rnd = 1'b1;
				state_d      = S_PMY;
			end
			S_PMY: begin
				cmd.push_mul = 1'b1;
				cmd.push_sel = 1'b1;
				state_d      = S_PRY;
			end
			S_PRY: begin
				cmd.push_rnd = 1'b1;
				cmd.push_sel = 1'b1;
				res_d        = sat_pkg::ST_OVL;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.clr_counts = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			poly_q  <= 1'b0;
			phase_q <= 1'b0;
			ei_q    <= '0;
			vi_q    <= '0;
			step_q  <= '0;
			res_q   <= sat_pkg::ST_SEP;
		end else begin
			state_q <= state_d;
			poly_q  <= poly_d;
			phase_q <= phase_d;
			ei_q    <= ei_d;
			vi_q    <= vi_d;
			step_q  <= step_d;
			res_q   <= res_d;
		end
	end

endmodule

@@ rtl/core/sat_dp.sv @@
// datapath of the collision test: vertex stores, edge and axis arithmetic, projections,
// best-axis tracking and the result register; depends on sat_pkg and sat_ram
module sat_dp #(
	parameter int MAX_VERTICES = 16,
	localparam int IW = $clog2(MAX_VERTICES),
	localparam int CW = $clog2(MAX_VERTICES + 2)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sat_pkg::cmd_t       cmd,
	input  logic [IW-1:0]       rd_addr,
	input  logic                in_valid,
	input  logic                which_polygon,
	input  logic signed [31:0]  vertex_x,
	input  logic signed [31:0]  vertex_y,
	input  logic                out_stall,
	output sat_pkg::sts_t       sts,
	output logic [CW-1:0]       cnt0,
	output logic [CW-1:0]       cnt1,
	output logic                out_valid,
	output logic [1:0]          status,
	output logic signed [31:0]  push_x,
	output logic signed [31:0]  push_y
);

	localparam int VW = sat_pkg::VTX_W;
	localparam int HW = sat_pkg::HALF_W;
	localparam int RW = sat_pkg::ROOT_W;
	localparam int LW = sat_pkg::LEN_W;
	localparam int FW = sat_pkg::FRAC_W;
	localparam int NW = sat_pkg::NORM_W;
	localparam int DW = sat_pkg::DIV_W;
	localparam int PW = sat_pkg::PROJ_W;
	localparam int GW = sat_pkg::DIFF_W;
	localparam int MW = sat_pkg::MTV_W;
	localparam int XW = sat_pkg::PROD_W;
	localparam int RND_SHIFT_W = sat_pkg::RND_SH;

	// ---------------- vertex stores and counts
	logic [CW-1:0] cnt0_q, cnt1_q;
	logic          in_acc, w0, w1;
	logic [VW-1:0] rdata0, rdata1, rdata;
	logic          rd_poly_s1;

	assign in_acc = in_valid & cmd.in_ready;
	assign w0 = in_acc & ~which_polygon & (cnt0_q < CW'(MAX_VERTICES));
	assign w1 = in_acc &  which_polygon & (cnt1_q < CW'(MAX_VERTICES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt0_q <= '0;
			cnt1_q <= '0;
		end else if (cmd.clr_counts) begin
			cnt0_q <= '0;
			cnt1_q <= '0;
		end else if (in_acc) begin
			// a full store parks at one past the limit to flag the overflow
			if (!which_polygon) begin
				cnt0_q <= w0 ? cnt0_q + CW'(1) : CW'(MAX_VERTICES + 1);
			end else begin
				cnt1_q <= w1 ? cnt1_q + CW'(1) : CW'(MAX_VERTICES + 1);
			end
		end
	end

	sat_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_ram0 (
		.clk   (clk),
		.we    (w0),
		.waddr (cnt0_q[IW-1:0]),
		.wdata ({vertex_y, vertex_x}),
		.raddr (rd_addr),
		.rdata (rdata0)
	);

	sat_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_ram1 (
		.clk   (clk),
		.we    (w1),
		.waddr (cnt1_q[IW-1:0]),
		.wdata ({vertex_y, vertex_x}),
		.raddr (rd_addr),
		.rdata (rdata1)
	);

	assign rdata = rd_poly_s1 ? rdata1 : rdata0;
	assign cnt0  = cnt0_q;
	assign cnt1  = cnt1_q;

	// ---------------- edge vector, halved magnitudes
	logic [VW-1:0]     a_q;
	logic signed [32:0] ex, ey;
	logic [32:0]       abs_x, abs_y;
	logic              shift_two, shift_one;
	logic [HW-1:0]     hx_q, hy_q;
	logic              exneg_q, eypos_q;

	assign ex = $signed({rdata[31], rdata[31:0]}) - $signed({a_q[31], a_q[31:0]});
	assign ey = $signed({rdata[63], rdata[63:32]}) - $signed({a_q[63], a_q[63:32]});
	assign abs_x = ex[32] ? $unsigned(-ex) : $unsigned(ex);
	assign abs_y = ey[32] ? $unsigned(-ey) : $unsigned(ey);
	assign shift_two = abs_x[32] | abs_y[32];
	assign shift_one = abs_x[31] | abs_y[31];

	always_ff @(posedge clk) begin
		if (cmd.ld_a) begin
			a_q <= rdata;
		end
		if (cmd.ld_edge) begin
			hx_q <= shift_two ? abs_x[32:2] : (shift_one ? abs_x[31:1] : abs_x[30:0]);
			hy_q <= shift_two ? abs_y[32:2] : (shift_one ? abs_y[31:1] : abs_y[30:0]);
			exneg_q <= ex[32];
			eypos_q <= ~ey[32] & (ey != '0);
		end
	end

	// ---------------- squared length and its integer root, two bits per step
	logic [HW-1:0]         sq_in;
	logic [sat_pkg::SQ_W-1:0] sq_prod, sqx_q, sqy_q;
	logic [RW-1:0]         rv_q, rr_q, rb_q, trial;
	logic [LW-1:0]         len;

	assign sq_in   = cmd.sq_x ? hx_q : hy_q;
	assign sq_prod = sat_pkg::SQ_W'(sq_in) * sat_pkg::SQ_W'(sq_in);
	assign trial   = rr_q + rb_q;
	assign len     = rr_q[LW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.sq_x) begin
			sqx_q <= sq_prod;
		end
		if (cmd.sq_y) begin
			sqy_q <= sq_prod;
		end
		if (cmd.sqrt_init) begin
			rv_q <= RW'(sqx_q) + RW'(sqy_q);
			rr_q <= '0;
			rb_q <= RW'(1) << (RW - 2);
		end else if (cmd.sqrt_step) begin
			if (rv_q >= trial) begin
				rv_q <= rv_q - trial;
				rr_q <= (rr_q >> 1) + rb_q;
			end else begin
				rr_q <= rr_q >> 1;
			end
			rb_q <= rb_q >> 2;
		end
	end

	// ---------------- two-lane restoring divider, one quotient bit per step
	logic [DW-1:0] remx_q, remy_q, dv_q;
	logic [NW-1:0] qx_q, qy_q;
	logic [FW-1:0] magx, magy;
	logic signed [NW-1:0] nx_q, ny_q;

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			remx_q <= DW'({hy_q, FW'(0)}) + DW'(len >> 1);
			remy_q <= DW'({hx_q, FW'(0)}) + DW'(len >> 1);
			dv_q   <= DW'({len, FW'(0)});
			qx_q   <= '0;
			qy_q   <= '0;
		end else if (cmd.div_step) begin
			if (remx_q >= dv_q) begin
				remx_q <= remx_q - dv_q;
				qx_q   <= {qx_q[NW-2:0], 1'b1};
			end else begin
				qx_q   <= {qx_q[NW-2:0], 1'b0};
			end
			if (remy_q >= dv_q) begin
				remy_q <= remy_q - dv_q;
				qy_q   <= {qy_q[NW-2:0], 1'b1};
			end else begin
				qy_q   <= {qy_q[NW-2:0], 1'b0};
			end
			dv_q <= dv_q >> 1;
		end
	end

	// top quotient bit set means the ratio reached one: clamp
	assign magx = qx_q[NW-1] ? {FW{1'b1}} : qx_q[FW-1:0];
	assign magy = qy_q[NW-1] ? {FW{1'b1}} : qy_q[FW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.norm_ld) begin
			if (len == '0) begin
				nx_q <= '0;
				ny_q <= '0;
			end else begin
				nx_q <= eypos_q ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
				ny_q <= exneg_q ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
			end
		end
	end

	// ---------------- projection pipeline: ram read, multiply, sum and min/max
	logic              pv_s1, pt_s1, pf_s1, pv_s2, pt_s2, pf_s2;
	logic signed [31:0] vx, vy;
	logic signed [PW-1:0] prx_s2, pry_s2, psum;
	logic signed [PW-1:0] mn0_q, mx0_q, mn1_q, mx1_q;

	assign vx   = $signed(rdata[31:0]);
	assign vy   = $signed(rdata[63:32]);
	assign psum = prx_s2 + pry_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
			pv_s2 <= 1'b0;
		end else begin
			pv_s1 <= cmd.proj_vld;
			pv_s2 <= pv_s1;
		end
	end

	always_ff @(posedge clk) begin
		rd_poly_s1 <= cmd.rd_poly;
		pt_s1  <= cmd.proj_tgt;
		pf_s1  <= cmd.proj_first;
		pt_s2  <= pt_s1;
		pf_s2  <= pf_s1;
		prx_s2 <= PW'(vx) * PW'(nx_q);
		pry_s2 <= PW'(vy) * PW'(ny_q);
		if (pv_s2) begin
			if (!pt_s2) begin
				if (pf_s2 || psum < mn0_q) mn0_q <= psum;
				if (pf_s2 || psum > mx0_q) mx0_q <= psum;
			end else begin
				if (pf_s2 || psum < mn1_q) mn1_q <= psum;
				if (pf_s2 || psum > mx1_q) mx1_q <= psum;
			end
		end
	end

	// ---------------- gap test and least-penetration axis
	logic signed [GW-1:0] d0_q, d1_q, dmax, best_q;
	logic signed [MW-1:0] bm_q;
	logic signed [NW-1:0] bnx_q, bny_q;
	logic                 have_q, sep;

	assign sep  = (d0_q > 0) || (d1_q > 0);
	assign dmax = (d0_q > d1_q) ? d0_q : d1_q;

	always_ff @(posedge clk) begin
		if (cmd.eval_diff) begin
			d0_q <= GW'(mn0_q) - GW'(mx1_q);
			d1_q <= GW'(mn1_q) - GW'(mx0_q);
		end
		if (cmd.eval_best && !sep && (!have_q || dmax > best_q)) begin
			best_q <= dmax;
			bm_q   <= (d0_q > d1_q) ? MW'(d0_q) : -MW'(d1_q);
			bnx_q  <= nx_q;
			bny_q  <= ny_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.test_init) begin
			have_q <= 1'b0;
		end else if (cmd.eval_best && !sep) begin
			have_q <= 1'b1;
		end
	end

	// ---------------- push vector: multiply, then round and saturate
	logic signed [NW-1:0] pn;
	logic [NW-1:0]        an;
	logic [MW-1:0]        am;
	logic [XW-1:0]        pprod_q, rsum;
	logic                 pneg_q;
	logic [XW-RND_SHIFT_W-1:0] rmag;
	logic signed [31:0]   pval, px_q, py_q;

	assign pn = cmd.push_sel ? bny_q : bnx_q;
	assign an = pn[NW-1] ? $unsigned(-pn) : $unsigned(pn);
	assign am = bm_q[MW-1] ? $unsigned(-bm_q) : $unsigned(bm_q);
	assign rsum = pprod_q + (XW'(1) << (RND_SHIFT_W - 1));
	assign rmag = rsum[XW-1:RND_SHIFT_W];

	always_comb begin
		if (pneg_q) begin
			if (rmag > (XW-RND_SHIFT_W)'(33'h080000000)) begin
				pval = 32'sh80000000;
			end else begin
				pval = -$signed(rmag[31:0]);
			end
		end else begin
			if (rmag > (XW-RND_SHIFT_W)'(32'h7fffffff)) begin
				pval = 32'sh7fffffff;
			end else begin
				pval = $signed(rmag[31:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_mul) begin
			pprod_q <= XW'(an[FW-1:0]) * XW'(am);
			pneg_q  <= pn[NW-1] ^ bm_q[MW-1];
		end
		if (cmd.push_rnd) begin
			if (cmd.push_sel) begin
				py_q <= pval;
			end else begin
				px_q <= pval;
			end
		end
	end

	// ---------------- result register
	logic              out_valid_q;
	sat_pkg::status_t  status_q;
	logic signed [31:0] push_x_q, push_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q <= cmd.out_st;
			push_x_q <= (cmd.out_st == sat_pkg::ST_OVL) ? px_q : '0;
			push_y_q <= (cmd.out_st == sat_pkg::ST_OVL) ? py_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign push_x    = push_x_q;
	assign push_y    = push_y_q;

	assign sts.cnt_err  = (cnt0_q == '0) || (cnt1_q == '0) ||
	                      (cnt0_q > CW'(MAX_VERTICES)) || (cnt1_q > CW'(MAX_VERTICES));
	assign sts.sep      = sep;
	assign sts.out_free = ~out_valid_q | ~out_stall;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt0_q <= CW'(MAX_VERTICES + 1)) && (cnt1_q <= CW'(MAX_VERTICES + 1)))
		else $error("vertex count beyond overflow mark");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result overwritten before it was taken");

	a_push_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != sat_pkg::ST_OVL) |-> (push_x_q == '0 && push_y_q == '0))
		else $error("nonzero push on a non-overlap result");

	a_cnt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_counts |=> (cnt0_q == '0 && cnt1_q == '0))
		else $error("vertex counts not cleared after a test");

endmodule
